// ===== design/qbez_pkg.sv =====
`timescale 1ns / 1ps
// qbez_pkg: shared constants, types and helpers of the quintic bezier point evaluator
// depends on nothing; used by the interfaces and every module of the block

package qbez_pkg;

   // table resolution and derived sizes
   localparam int TABLE_STEPS = 4096;
   localparam int LAST_STEP   = TABLE_STEPS - 1;
   localparam int ADDR_W      = $clog2(TABLE_STEPS);

   // field widths
   localparam int NUM_PTS   = 6;
   localparam int PARAM_W   = 17;
   localparam int COORD_W   = 21;
   localparam int POINT_W   = 3 * COORD_W;
   localparam int W_W       = 17;
   localparam int CSR_IDX_W = 3;

   // q1.16 one and the per-step increment of u, split into quotient and remainder
   localparam int ONE_Q16    = 65536;
   localparam int HALF_Q16   = 32768;
   localparam int STEP_Q     = ONE_Q16 / TABLE_STEPS;
   localparam int STEP_R     = ONE_Q16 % TABLE_STEPS;
   localparam int HALF_STEPS = TABLE_STEPS / 2;

   // accumulation widths: weight (as signed) times coordinate, then six terms
   localparam int MUL_W = W_W + 1 + COORD_W;
   localparam int SUM_W = MUL_W + 3;
   localparam int SH_W  = SUM_W - 16;

   // binomial coefficients of degree five
   localparam logic [3:0] BINOM5 [NUM_PTS] = '{4'd1, 4'd5, 4'd10, 4'd10, 4'd5, 4'd1};

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_POINT0 = 3'd0,
      REG_POINT1 = 3'd1,
      REG_POINT2 = 3'd2,
      REG_POINT3 = 3'd3,
      REG_POINT4 = 3'd4,
      REG_POINT5 = 3'd5
   } csr_reg_type;

   typedef logic [PARAM_W-1:0]        param_type;
   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [POINT_W-1:0]        point_type;
   typedef logic [CSR_IDX_W-1:0]      csr_idx_type;
   typedef point_type [NUM_PTS-1:0]   pts_type;
   typedef logic [NUM_PTS-1:0][W_W-1:0] wrow_type;

   // table read port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } rd_port_type;

   // table write request from the weight pipeline
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] k;
      wrow_type          row;
   } wcalc_out_type;

   // evaluated point
   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } pos_type;

   // rounded q1.16 product
   function automatic logic [W_W-1:0] q16_mul(input logic [W_W-1:0] a,
                                              input logic [W_W-1:0] b);
      logic [2*W_W-1:0] p;
      p = a * b + (2*W_W)'(HALF_Q16);
      return p[W_W+15:16];
   endfunction

endpackage

// ===== design/qbez_if.sv =====
`timescale 1ns / 1ps
// qbez_if: valid/ready channel interfaces of the quintic bezier point evaluator
// depends on qbez_pkg for the payload types

interface qbez_req_if;
   import qbez_pkg::*;
   logic      valid;
   logic      ready;
   param_type curve_param;
   modport source (output valid, output curve_param, input ready);
   modport sink   (input valid, input curve_param, output ready);
endinterface

interface qbez_rsp_if;
   import qbez_pkg::*;
   logic      valid;
   logic      ready;
   coord_type pos_x;
   coord_type pos_y;
   coord_type pos_z;
   modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface qbez_csr_if;
   import qbez_pkg::*;
   logic        valid;
   logic        ready;
   csr_idx_type index;
   point_type   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/quintic_bezier_point_eval.sv =====
`timescale 1ns / 1ps
// Quintic bezier point evaluator: takes a curve parameter t (q1.16) per transaction
// and returns the point on the degree-5 curve through six configured control points,
// one transaction per cycle sustained unless the response side stalls; the result
// passes the scale, table read, product, pair sum, total and output registers. Weights
// come from a TABLE_STEPS-entry memory read once per transaction; after reset that
// memory is filled one step a cycle, and the request channel stays not-ready until the
// fill is done. Control-point writes are taken at any time but must only be issued
// while no transaction is in flight. Depends on qbez_pkg, qbez_if, qbez_table, qbez_mac.

module quintic_bezier_point_eval (
   input logic        clock,
   input logic        reset,
   qbez_req_if.sink   req_ch,
   qbez_rsp_if.source rsp_ch,
   qbez_csr_if.sink   csr_ch
);
   import qbez_pkg::*;

   localparam int PROD_W = PARAM_W + ADDR_W;
   localparam int KR_W   = ADDR_W + 2;

   pts_type           point_ff;
   logic              adv, tbl_ready, req_acc, rsp_vld;
   param_type         t_clamp;
   logic [PROD_W-1:0] prod_in, prod_ff;
   logic              v1_ff, v2_ff;
   logic [KR_W-1:0]   k_rnd;
   rd_port_type       rd_port;
   wrow_type          row;
   pos_type           pos;

   // control point registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_ff <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_POINT0: point_ff[0] <= csr_ch.data;
            REG_POINT1: point_ff[1] <= csr_ch.data;
            REG_POINT2: point_ff[2] <= csr_ch.data;
            REG_POINT3: point_ff[3] <= csr_ch.data;
            REG_POINT4: point_ff[4] <= csr_ch.data;
            REG_POINT5: point_ff[5] <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // pipeline advances whenever the output register is free or being taken
   assign adv          = !rsp_vld || rsp_ch.ready;
   assign req_ch.ready = adv && tbl_ready;
   assign req_acc      = req_ch.valid && req_ch.ready;

   // clamp t to one and scale to table steps
   assign t_clamp = (req_ch.curve_param > PARAM_W'(ONE_Q16)) ? PARAM_W'(ONE_Q16)
                                                             : req_ch.curve_param;
   assign prod_in = PROD_W'(t_clamp) * PROD_W'(LAST_STEP);

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_acc;
         v2_ff <= v1_ff;
      end
   end

   // step index, rounding up only above an exact half
   assign k_rnd = KR_W'(prod_ff[PROD_W-1:16]) + KR_W'(prod_ff[15:0] > 16'h8000);

   assign rd_port.en   = adv;
   assign rd_port.addr = (k_rnd > KR_W'(LAST_STEP)) ? ADDR_W'(LAST_STEP)
                                                    : k_rnd[ADDR_W-1:0];

   qbez_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_port (rd_port),
      .rd_row  (row),
      .ready   (tbl_ready)
   );

   qbez_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v2_ff),
      .row       (row),
      .points    (point_ff),
      .out_valid (rsp_vld),
      .out_pos   (pos)
   );

   // response channel
   assign rsp_ch.valid = rsp_vld;
   assign rsp_ch.pos_x = pos.x;
   assign rsp_ch.pos_y = pos.y;
   assign rsp_ch.pos_z = pos.z;

endmodule

// ===== design/qbez_wcalc.sv =====
`timescale 1ns / 1ps
// qbez_wcalc: pipelined bernstein weight generator, one table step per cycle
// depends on qbez_pkg

module qbez_wcalc (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [qbez_pkg::ADDR_W-1:0]  in_k,
   input  logic [qbez_pkg::PARAM_W-1:0] in_u,
   output qbez_pkg::wcalc_out_type   out
);
   import qbez_pkg::*;

   // stage 0 holds powers 0..1, stage s holds powers 0..s+1
   localparam int POW_STG = NUM_PTS - 1;
   localparam int DEPTH   = POW_STG + 2;
   localparam int WX_W    = 2 * W_W + 4;

   wrow_type          pu_in [POW_STG];
   wrow_type          pv_in [POW_STG];
   wrow_type          pu_ff [POW_STG];
   wrow_type          pv_ff [POW_STG];
   logic [ADDR_W-1:0] k_ff [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [2*W_W-1:0]  bp_ff [NUM_PTS];
   logic [WX_W-1:0]   wx [NUM_PTS];
   wrow_type          w_in, w_ff;

   // powers of u and v = 1 - u at stage entry, then one more power per stage
   always_comb begin
      pu_in[0]    = '0;
      pv_in[0]    = '0;
      pu_in[0][0] = W_W'(ONE_Q16);
      pv_in[0][0] = W_W'(ONE_Q16);
      pu_in[0][1] = in_u;
      pv_in[0][1] = W_W'(ONE_Q16) - in_u;
      for (int s = 1; s < POW_STG; s++) begin
         pu_in[s]      = pu_ff[s-1];
         pv_in[s]      = pv_ff[s-1];
         pu_in[s][s+1] = q16_mul(pu_ff[s-1][s], pu_ff[s-1][1]);
         pv_in[s][s+1] = q16_mul(pv_ff[s-1][s], pv_ff[s-1][1]);
      end
   end

   // binomial scaling and rounding of the power products
   always_comb begin
      for (int i = 0; i < NUM_PTS; i++) begin
         wx[i]   = WX_W'(bp_ff[i]) * WX_W'(BINOM5[i]) + WX_W'(HALF_Q16);
         w_in[i] = wx[i][W_W+15:16];
      end
   end

   // payload stages: one power per stage, then the cross product, then the weight
   always_ff @(posedge clock) begin
      for (int s = 0; s < POW_STG; s++) begin
         pu_ff[s] <= pu_in[s];
         pv_ff[s] <= pv_in[s];
      end
      k_ff[0] <= in_k;
      for (int j = 1; j < DEPTH; j++) begin
         k_ff[j] <= k_ff[j-1];
      end
      for (int i = 0; i < NUM_PTS; i++) begin
         bp_ff[i] <= pu_ff[POW_STG-1][i] * pv_ff[POW_STG-1][NUM_PTS-1-i];
      end
      w_ff <= w_in;
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[DEPTH-2:0], in_valid};
      end
   end

   assign out.valid = vld_ff[DEPTH-1];
   assign out.k     = k_ff[DEPTH-1];
   assign out.row   = w_ff;

endmodule

// ===== design/qbez_table.sv =====
`timescale 1ns / 1ps
// qbez_table: weight table memory with its fill sequencer after reset
// depends on qbez_pkg and qbez_wcalc

module qbez_table (
   input  logic                  clock,
   input  logic                  reset,
   input  qbez_pkg::rd_port_type rd_port,
   output qbez_pkg::wrow_type    rd_row,
   output logic                  ready
);
   import qbez_pkg::*;

   typedef enum logic [1:0] {
      ST_FILL = 2'b01,
      ST_RUN  = 2'b10
   } tbl_state_type;

   localparam int ACC_W = ADDR_W + 1;

   tbl_state_type     state_ff, state_in;
   logic              iss_act_ff, iss_act_in;
   logic [ADDR_W-1:0] iss_k_ff, iss_k_in;
   logic [PARAM_W-1:0] q_ff, q_in;
   logic [ACC_W-1:0]  r_ff, r_in, r_sum;
   wcalc_out_type     wr;
   wrow_type          mem [TABLE_STEPS];
   wrow_type          rd_row_ff;

   // step sequencer: u = round(k * 65536 / steps) kept as quotient and remainder
   always_comb begin
      state_in   = state_ff;
      iss_act_in = iss_act_ff;
      iss_k_in   = iss_k_ff;
      q_in       = q_ff;
      r_in       = r_ff;
      r_sum      = r_ff + ACC_W'(STEP_R);
      if (iss_act_ff) begin
         iss_k_in = iss_k_ff + 1'b1;
         if (r_sum >= ACC_W'(TABLE_STEPS)) begin
            r_in = r_sum - ACC_W'(TABLE_STEPS);
            q_in = q_ff + PARAM_W'(STEP_Q + 1);
         end else begin
            r_in = r_sum;
            q_in = q_ff + PARAM_W'(STEP_Q);
         end
         if (iss_k_ff == ADDR_W'(LAST_STEP)) begin
            iss_act_in = 1'b0;
         end
      end
      if (state_ff == ST_FILL && wr.valid && wr.k == ADDR_W'(LAST_STEP)) begin
         state_in = ST_RUN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_FILL;
         iss_act_ff <= 1'b1;
         iss_k_ff   <= '0;
         q_ff       <= '0;
         r_ff       <= ACC_W'(HALF_STEPS);
      end else begin
         state_ff   <= state_in;
         iss_act_ff <= iss_act_in;
         iss_k_ff   <= iss_k_in;
         q_ff       <= q_in;
         r_ff       <= r_in;
      end
   end

   qbez_wcalc u_wcalc (
      .clock    (clock),
      .reset    (reset),
      .in_valid (iss_act_ff),
      .in_k     (iss_k_ff),
      .in_u     (q_ff),
      .out      (wr)
   );

   // weight memory: written during the fill, read through a registered output
   always_ff @(posedge clock) begin
      if (wr.valid) begin
         mem[wr.k] <= wr.row;
      end
      if (rd_port.en) begin
         rd_row_ff <= mem[rd_port.addr];
      end
   end

   assign rd_row = rd_row_ff;
   assign ready  = (state_ff == ST_RUN);

endmodule

// ===== design/qbez_mac.sv =====
`timescale 1ns / 1ps
// qbez_mac: weighted sum of the six control points per axis, rounding and saturation
// depends on qbez_pkg

module qbez_mac (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  qbez_pkg::wrow_type row,
   input  qbez_pkg::pts_type  points,
   output logic              out_valid,
   output qbez_pkg::pos_type out_pos
);
   import qbez_pkg::*;

   localparam int NUM_AX   = 3;
   localparam int NUM_PAIR = NUM_PTS / 2;
   localparam int STAGES   = 4;

   logic signed [MUL_W-1:0] term_ff [NUM_AX][NUM_PTS];
   logic signed [MUL_W:0]   pair_ff [NUM_AX][NUM_PAIR];
   logic signed [SUM_W-1:0] sum_in [NUM_AX];
   logic signed [SUM_W-1:0] sum_ff [NUM_AX];
   logic [SH_W-1:0]         sh [NUM_AX];
   coord_type               crd_in [NUM_AX];
   coord_type               crd_ff [NUM_AX];
   logic [STAGES-1:0]       vld_ff;

   // three-term sum with the rounding half, then floor shift and saturation
   always_comb begin
      for (int a = 0; a < NUM_AX; a++) begin
         sum_in[a] = SUM_W'(HALF_Q16);
         for (int j = 0; j < NUM_PAIR; j++) begin
            sum_in[a] = sum_in[a] + SUM_W'(pair_ff[a][j]);
         end
         sh[a] = sum_ff[a][SUM_W-1:16];
         if ((&sh[a][SH_W-1:COORD_W-1]) || !(|sh[a][SH_W-1:COORD_W-1])) begin
            crd_in[a] = sh[a][COORD_W-1:0];
         end else if (sh[a][SH_W-1]) begin
            crd_in[a] = {1'b1, {(COORD_W-1){1'b0}}};
         end else begin
            crd_in[a] = {1'b0, {(COORD_W-1){1'b1}}};
         end
      end
   end

   // products, pair sums, total, output
   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < NUM_AX; a++) begin
            for (int i = 0; i < NUM_PTS; i++) begin
               term_ff[a][i] <= $signed({1'b0, row[i]}) *
                                $signed(points[i][a*COORD_W +: COORD_W]);
            end
            for (int j = 0; j < NUM_PAIR; j++) begin
               pair_ff[a][j] <= (MUL_W+1)'(term_ff[a][2*j]) +
                                (MUL_W+1)'(term_ff[a][2*j+1]);
            end
            sum_ff[a] <= sum_in[a];
            crd_ff[a] <= crd_in[a];
         end
      end
   end

   // valid chain, frozen with the data on a stall
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_pos.x = crd_ff[0];
   assign out_pos.y = crd_ff[1];
   assign out_pos.z = crd_ff[2];

endmodule

// ===== design/qbez_checker.sv =====
`timescale 1ns / 1ps
// qbez_checker: port-level assertions for the quintic bezier point evaluator
// depends on qbez_pkg; bound to quintic_bezier_point_eval at the end of this file

module qbez_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input qbez_pkg::coord_type pos_x,
   input qbez_pkg::coord_type pos_y,
   input qbez_pkg::coord_type pos_z
);
   import qbez_pkg::*;

   logic [3:0] pend_ff;

   // transactions accepted but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 4'(req_valid && req_ready) - 4'(rsp_valid && rsp_ready);
      end
   end

   // table fill keeps requests out after reset
   a_fill_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request accepted during table fill");

   // nothing to answer straight after reset
   a_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // every response belongs to an earlier request
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 4'd0)
      else $error("response without an outstanding request");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pos_x) && $stable(pos_y)
                                   && $stable(pos_z))
      else $error("stalled response changed");

endmodule

bind quintic_bezier_point_eval qbez_checker u_qbez_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .pos_x     (rsp_ch.pos_x),
   .pos_y     (rsp_ch.pos_y),
   .pos_z     (rsp_ch.pos_z)
);
